@@ rtl/rdro_pkg.sv @@
// Shared types and constants for the receive descriptor ring ownership core
package rdro_pkg;

   // Ring geometry
   localparam int RING_DEPTH = 4;
   localparam int IDX_W      = $clog2(RING_DEPTH);
   localparam int LEN_W      = 16;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

   // Buffer length after reset
   localparam logic [LEN_W-1:0] BUF_LEN_RESET = LEN_W'(64);

   // Request opcodes
   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_SERVICE = 1'b1;

   // Response kinds
   typedef enum logic [1:0] {
      KIND_ACCEPT  = 2'd0,
      KIND_REFUSE  = 2'd1,
      KIND_DELIVER = 2'd2
   } kind_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ARRIVE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   // One descriptor as held in the ring memory
   typedef struct packed {
      logic             own;
      logic [LEN_W-1:0] length;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{own: 1'b1, length: '0};

endpackage

@@ rtl/rx_descriptor_ring_ownership_core.sv @@
// Receive descriptor ring with one ownership bit per entry, memory based
//
//   channel   ports                                  handshake
//   request   req_opcode, req_packet_length          start & !busy
//   response  rsp_kind, rsp_entry_index,             rsp_valid, one cycle, no stall
//             rsp_stored_length, rsp_last
//   config    csr_wr_data                            csr_wr_en
//
// A packet arrival first reads the head entry from the ring memory, then updates
// it and registers the response. In a service pass the ring memory is read one
// entry a cycle, and a final flush state drains the held response that carries
// last. Reset is synchronous; the ring needs no clearing pass, as per-entry valid
// bits return the reset descriptor until first written. The receiver cannot
// stall; busy stays high until the final response is registered, and that
// response shows in the next idle cycle.
module rx_descriptor_ring_ownership_core
   import rdro_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             req_opcode,
   input  logic [LEN_W-1:0] req_packet_length,
   output logic             rsp_valid,
   output logic [1:0]       rsp_kind,
   output logic [IDX_W-1:0] rsp_entry_index,
   output logic [LEN_W-1:0] rsp_stored_length,
   output logic             rsp_last,
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_wr_data
);

   // Ring memory and per-entry valid bits
   entry_type              ring_mem [RING_DEPTH];
   logic [RING_DEPTH-1:0]  entry_valid_ff;

   state_type              state_ff, state_in;
   logic [LEN_W-1:0]       buf_len_ff;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [LEN_W-1:0]       plen_ff, plen_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   entry_type              rd_data_ff;
   logic                   rd_valid_ff;

   // Held delivery, emitted once the next one is found or the scan ends
   logic                   pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]       pend_idx_ff, pend_idx_in;
   logic [LEN_W-1:0]       pend_len_ff, pend_len_in;

   // Response registers
   logic                   out_valid_ff, out_valid_in;
   kind_type               out_kind_ff, out_kind_in;
   logic [IDX_W-1:0]       out_idx_ff, out_idx_in;
   logic [LEN_W-1:0]       out_len_ff, out_len_in;
   logic                   out_last_ff, out_last_in;

   // Memory access controls
   logic [IDX_W-1:0]       rd_addr;
   logic                   mem_we;
   logic [IDX_W-1:0]       wr_addr;
   entry_type              wr_data;

   entry_type              entry_cur;
   logic [LEN_W-1:0]       clamp_len;
   logic [IDX_W-1:0]       idx_next;

   // Substitute the reset descriptor for entries never written
   assign entry_cur = rd_valid_ff ? rd_data_ff : ENTRY_RESET;
   assign clamp_len = (plen_ff < buf_len_ff) ? plen_ff : buf_len_ff;
   assign idx_next  = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + IDX_W'(1);

   // Sequence reads, write-backs and responses
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      plen_in       = plen_ff;
      rd_idx_in     = rd_idx_ff;
      rd_addr       = rd_idx_ff;
      mem_we        = 1'b0;
      wr_addr       = rd_idx_ff;
      wr_data       = entry_cur;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_len_in   = pend_len_ff;
      out_valid_in  = 1'b0;
      out_kind_in   = KIND_ACCEPT;
      out_idx_in    = rd_idx_ff;
      out_len_in    = '0;
      out_last_in   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               plen_in       = req_packet_length;
               pend_valid_in = 1'b0;
               if (req_opcode == OP_ARRIVAL) begin
                  rd_addr   = head_ff;
                  rd_idx_in = head_ff;
                  state_in  = ST_ARRIVE;
               end else begin
                  rd_addr   = '0;
                  rd_idx_in = '0;
                  state_in  = ST_SCAN;
               end
            end
         end

         ST_ARRIVE: begin
            out_valid_in = 1'b1;
            out_last_in  = 1'b1;
            out_idx_in   = rd_idx_ff;
            if (entry_cur.own) begin
               // Store clamped length, hand to software, advance head
               mem_we         = 1'b1;
               wr_data.own    = 1'b0;
               wr_data.length = clamp_len;
               out_kind_in    = KIND_ACCEPT;
               out_len_in     = clamp_len;
               head_in        = idx_next;
            end else begin
               out_kind_in = KIND_REFUSE;
               out_len_in  = '0;
            end
            state_in = ST_IDLE;
         end

         ST_SCAN: begin
            // Write back one entry while the next one is read
            if (!entry_cur.own) begin
               mem_we      = 1'b1;
               wr_data.own = 1'b1;
               if (pend_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_kind_in  = KIND_DELIVER;
                  out_idx_in   = pend_idx_ff;
                  out_len_in   = pend_len_ff;
                  out_last_in  = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_idx_in   = rd_idx_ff;
               pend_len_in   = entry_cur.length;
            end
            if (rd_idx_ff == LAST_IDX) begin
               state_in = ST_FLUSH;
            end else begin
               rd_idx_in = idx_next;
               rd_addr   = idx_next;
            end
         end

         ST_FLUSH: begin
            // Drain the held delivery as the final response
            if (pend_valid_ff) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_DELIVER;
               out_idx_in   = pend_idx_ff;
               out_len_in   = pend_len_ff;
               out_last_in  = 1'b1;
            end
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_ff        <= '0;
         buf_len_ff     <= BUF_LEN_RESET;
         entry_valid_ff <= '0;
         pend_valid_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         if (csr_wr_en) begin
            buf_len_ff <= csr_wr_data;
         end
         if (mem_we) begin
            entry_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      plen_ff     <= plen_in;
      rd_idx_ff   <= rd_idx_in;
      pend_idx_ff <= pend_idx_in;
      pend_len_ff <= pend_len_in;
      out_kind_ff <= out_kind_in;
      out_idx_ff  <= out_idx_in;
      out_len_ff  <= out_len_in;
      out_last_ff <= out_last_in;
   end

   // Ring memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[wr_addr] <= wr_data;
      end
      rd_data_ff  <= ring_mem[rd_addr];
      rd_valid_ff <= entry_valid_ff[rd_addr];
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_kind_ff;
   assign rsp_entry_index   = out_idx_ff;
   assign rsp_stored_length = out_len_ff;
   assign rsp_last          = out_last_ff;

endmodule
